// File: hdl/tag_level_cache_heap_replace_assert.svh
// Assertion macros used by the checker module.
`ifndef TAG_LEVEL_CACHE_HEAP_REPLACE_ASSERT_SVH
`define TAG_LEVEL_CACHE_HEAP_REPLACE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tlc_pkg.sv
package tlc_pkg;

  localparam int CACHE_ENTRIES = 31;
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);
  localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
  localparam int HALF_ENTRIES  = CACHE_ENTRIES / 2;
  localparam int KEY_W         = 32;
  localparam int LVL_W         = 3;
  localparam int GEN_W         = 29;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LVL_W-1:0] level;
    logic [GEN_W-1:0] gen;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: hdl/tlc_ram.sv
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tlc_ctrl.sv
module tlc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [tlc_pkg::KEY_W-1:0]  in_key,
  input  logic [tlc_pkg::LVL_W-1:0]  in_level_in,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [tlc_pkg::LVL_W-1:0]  out_level_out,
  output tlc_pkg::mem_req_t          mem_req,
  input  tlc_pkg::entry_t            rd_entry
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_INS      = 3'd2;
  localparam logic [2:0] ST_SIFT_RL  = 3'd3;
  localparam logic [2:0] ST_SIFT_RR  = 3'd4;
  localparam logic [2:0] ST_SIFT_CMP = 3'd5;

  localparam int IW = tlc_pkg::IDX_W;
  localparam int CW = tlc_pkg::CNT_W;

  logic [2:0]                state_r, state_nxt;
  logic [CW-1:0]             filled_r, filled_nxt;
  logic [tlc_pkg::GEN_W-1:0] gen_r, gen_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      cmp_pend_r, cmp_pend_nxt;

  logic [tlc_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [tlc_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0]             scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]             pos_r, pos_nxt;
  tlc_pkg::entry_t           cur_r, cur_nxt;
  tlc_pkg::entry_t           child_r, child_nxt;
  logic [IW-1:0]             child_idx_r, child_idx_nxt;
  logic                      hit_r, hit_nxt;
  logic [tlc_pkg::LVL_W-1:0] hlvl_r, hlvl_nxt;
  logic                      out_hit_r, out_hit_nxt;
  logic [tlc_pkg::LVL_W-1:0] out_lvl_r, out_lvl_nxt;

  logic [CW-1:0] left_w;
  logic [CW-1:0] right_w;
  logic          full;
  logic          pos_lt_half;

  // children of the current heap slot, only used while pos < half
  assign left_w      = CW'({pos_r, 1'b1});
  assign right_w     = left_w + CW'(1);
  assign full        = (filled_r == CW'(tlc_pkg::CACHE_ENTRIES));
  assign pos_lt_half = (pos_r < IW'(tlc_pkg::HALF_ENTRIES));

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    gen_nxt       = gen_r;
    out_valid_nxt = 1'b0;
    cmp_pend_nxt  = cmp_pend_r;
    key_nxt       = key_r;
    lvl_nxt       = lvl_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    child_nxt     = child_r;
    child_idx_nxt = child_idx_r;
    hit_nxt       = hit_r;
    hlvl_nxt      = hlvl_r;
    out_hit_nxt   = out_hit_r;
    out_lvl_nxt   = out_lvl_r;
    mem_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt      = in_key;
          lvl_nxt      = in_level_in;
          scan_idx_nxt = '0;
          cmp_pend_nxt = 1'b0;
          state_nxt    = (in_op == tlc_pkg::OP_INSERT) ? ST_INS : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // one read issued per cycle, compared against the registered RAM output
        if (cmp_pend_r && (rd_entry.key == key_r)) begin
          if (full) begin
            cur_nxt.key   = rd_entry.key;
            cur_nxt.level = rd_entry.level;
            cur_nxt.gen   = gen_r;
            gen_nxt       = gen_r + tlc_pkg::GEN_W'(1);
            pos_nxt       = cmp_idx_r;
            hit_nxt       = 1'b1;
            hlvl_nxt      = rd_entry.level;
            state_nxt     = ST_SIFT_RL;
          end else begin
            out_valid_nxt = 1'b1;
            out_hit_nxt   = 1'b1;
            out_lvl_nxt   = rd_entry.level;
            state_nxt     = ST_IDLE;
          end
        end else if (scan_idx_r < filled_r) begin
          mem_req.raddr = IW'(scan_idx_r);
          cmp_pend_nxt  = 1'b1;
          cmp_idx_nxt   = IW'(scan_idx_r);
          scan_idx_nxt  = scan_idx_r + CW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_lvl_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_INS: begin
        gen_nxt = gen_r + tlc_pkg::GEN_W'(1);
        if (!full) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = IW'(filled_r);
          mem_req.wdata.key   = key_r;
          mem_req.wdata.level = lvl_r;
          mem_req.wdata.gen   = gen_r;
          filled_nxt          = filled_r + CW'(1);
          out_valid_nxt       = 1'b1;
          out_hit_nxt         = 1'b0;
          out_lvl_nxt         = '0;
          state_nxt           = ST_IDLE;
        end else begin
          cur_nxt.key   = key_r;
          cur_nxt.level = lvl_r;
          cur_nxt.gen   = gen_r;
          pos_nxt       = '0;
          hit_nxt       = 1'b0;
          hlvl_nxt      = '0;
          state_nxt     = ST_SIFT_RL;
        end
      end

      ST_SIFT_RL: begin
        if (pos_lt_half) begin
          mem_req.raddr = IW'(left_w);
          state_nxt     = ST_SIFT_RR;
        end else begin
          // moving item lands in its final slot
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = cur_r;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_lvl_nxt   = hlvl_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_SIFT_RR: begin
        child_nxt     = rd_entry;
        child_idx_nxt = IW'(left_w);
        if (right_w < CW'(tlc_pkg::CACHE_ENTRIES)) begin
          mem_req.raddr = IW'(right_w);
          state_nxt     = ST_SIFT_CMP;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = rd_entry;
          pos_nxt       = IW'(left_w);
          state_nxt     = ST_SIFT_RL;
        end
      end

      ST_SIFT_CMP: begin
        // right child wins a tie
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        if (child_r.gen < rd_entry.gen) begin
          mem_req.wdata = child_r;
          pos_nxt       = child_idx_r;
        end else begin
          mem_req.wdata = rd_entry;
          pos_nxt       = IW'(right_w);
        end
        state_nxt = ST_SIFT_RL;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= '0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    lvl_r       <= lvl_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    child_r     <= child_nxt;
    child_idx_r <= child_idx_nxt;
    hit_r       <= hit_nxt;
    hlvl_r      <= hlvl_nxt;
    out_hit_r   <= out_hit_nxt;
    out_lvl_r   <= out_lvl_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_level_out = out_lvl_r;

endmodule

// File: hdl/tag_level_cache_heap_replace.sv
// Key-to-level cache, 31 entries, approximate LRU via a generation min-heap.
// Command port: an item (in_op, in_key, in_level_in) is taken on a clock edge
// with start high and busy low. in_op lookup searches for in_key; in_op insert
// stores in_key/in_level_in, appending until full, then replacing the heap root.
// Each item gives exactly one result: out_valid pulses for one cycle with
// out_hit and out_level_out (both zero on a miss or an insert). The receiver
// cannot stall; results are never held back or dropped.
// Steps: an insert while not full writes the new entry at the end in ST_INS;
// a lookup reads the filled entries in order and stops at the first hit. When
// the cache is full, a hit or an insert also sifts the entry down the heap,
// each level passing through ST_SIFT_RL, ST_SIFT_RR and ST_SIFT_CMP, with a
// final write in ST_SIFT_RL.
// Cost is set by the single-read-port entry RAM: the key scan reads one entry
// a cycle, and each sift level reads both children before writing back.
// One item at a time; busy stays high until the strobe cycle, and a new item
// may be started in that cycle.
// Reset (rst_n low, synchronous) empties the cache and zeroes the generation
// counter; entry RAM contents are not cleared and are never read unwritten.
module tag_level_cache_heap_replace (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [tlc_pkg::KEY_W-1:0]  in_key,
  input  logic [tlc_pkg::LVL_W-1:0]  in_level_in,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [tlc_pkg::LVL_W-1:0]  out_level_out
);

  tlc_pkg::mem_req_t                  mem_req;
  logic [$bits(tlc_pkg::entry_t)-1:0] ram_rdata;
  tlc_pkg::entry_t                    rd_entry;

  assign rd_entry = tlc_pkg::entry_t'(ram_rdata);

  tlc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_level_in   (in_level_in),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_level_out (out_level_out),
    .mem_req       (mem_req),
    .rd_entry      (rd_entry)
  );

  tlc_ram #(
    .WIDTH ($bits(tlc_pkg::entry_t)),
    .DEPTH (tlc_pkg::CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: hdl/tlc_chk.sv
`include "tag_level_cache_heap_replace_assert.svh"

module tlc_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_hit,
  input logic [tlc_pkg::LVL_W-1:0]  out_level_out
);

  // an accepted item keeps the block busy until its result
  `TLC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // result only shows once the item has finished
  `TLC_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while busy")

  // an item always passes through a busy state before its result, so strobes never run together
  `TLC_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")

  // a miss or insert reports level zero
  `TLC_ASSERT_NOW(a_miss_level, out_valid && !out_hit, out_level_out == '0, "nonzero level")

endmodule

bind tag_level_cache_heap_replace tlc_chk u_tlc_chk (.*);
